>>> rtl/core/tvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvg_pkg;

	localparam int PHASE_W    = 32;
	localparam int XY_W       = 32;
	localparam int Z_W        = 34;
	localparam int ATAN_COUNT = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

	// arctan(2^-i) in turns, 2^32 = one full turn
	localparam logic [31:0] ATAN_TURNS [0:ATAN_COUNT-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAJOR_RADIUS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINOR_RADIUS = 2'd3;

	// grid sizes here are already masked and never zero
	typedef struct packed {
		logic [7:0]         grid_columns;
		logic [7:0]         grid_rows;
		logic signed [15:0] ring_radius;
		logic signed [15:0] tube_radius;
	} tvg_cfg_t;

	function automatic logic signed [17:0] clamp_pos(input logic signed [20:0] v);
		if (v > 21'sd131071)
			return 18'sd131071;
		else if (v < -21'sd131072)
			return -18'sd131072;
		else
			return v[17:0];
	endfunction

	function automatic logic signed [15:0] clamp_norm(input logic signed [18:0] v);
		if (v > 19'sd16384)
			return 16'sd16384;
		else if (v < -19'sd16384)
			return -16'sd16384;
		else
			return v[15:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tvg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tvg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] col_index;
	logic [7:0] row_index;

	modport source (output valid, output col_index, output row_index, input ready);
	modport sink (input valid, input col_index, input row_index, output ready);
endinterface

interface tvg_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] pos_x;
	logic signed [17:0] pos_y;
	logic signed [17:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic               cell_valid;
	logic [15:0]        idx_corner00;
	logic [15:0]        idx_corner10;
	logic [15:0]        idx_corner01;
	logic [15:0]        idx_corner11;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output cell_valid,
		output idx_corner00, output idx_corner10, output idx_corner01,
		output idx_corner11, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input cell_valid,
		input idx_corner00, input idx_corner10, input idx_corner01,
		input idx_corner11, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tvg_phase.sv
`timescale 1ns / 1ps
`default_nettype none
// phase = round(2^32 * (k mod n) / n), one remainder or quotient bit per stage
module tvg_phase
	import tvg_pkg::*;
#(
	parameter int GB = 8
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [GB-1:0]      k,
	input  wire logic [GB-1:0]      n,
	output logic      [PHASE_W-1:0] phase
);

	logic [GB-1:0]      mr_q [0:GB-1];
	logic [GB:0]        dr_q [0:PHASE_W-1];
	logic [PHASE_W-1:0] dq_q [0:PHASE_W-1];

	genvar s, t;

	for (s = 0; s < GB; s++) begin : g_mod
		logic [GB-1:0]   r_in;
		logic [2*GB-1:0] dsh;
		if (s == 0) begin : g_first
			assign r_in = k;
		end else begin : g_next
			assign r_in = mr_q[s-1];
		end
		assign dsh = {{GB{1'b0}}, n} << (GB - 1 - s);
		always_ff @(posedge clk) begin
			if (en)
				mr_q[s] <= ({{GB{1'b0}}, r_in} >= dsh) ? r_in - dsh[GB-1:0] : r_in;
		end
	end

	// divide (k mod n)*2^33 + n by 2n; the low dividend bits are the bits of n
	for (t = 0; t < PHASE_W; t++) begin : g_div
		logic [GB:0]        rem_in;
		logic [PHASE_W-1:0] q_in;
		logic               b;
		logic [GB+1:0]      tr;
		logic [GB+1:0]      dv;
		logic [GB+1:0]      diff;
		logic               ge;
		if (t == 0) begin : g_first
			assign rem_in = {mr_q[GB-1], 1'b0};
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = dr_q[t-1];
			assign q_in   = dq_q[t-1];
		end
		if (PHASE_W - 1 - t < GB) begin : g_nbit
			assign b = n[PHASE_W-1-t];
		end else begin : g_zero
			assign b = 1'b0;
		end
		assign tr   = {rem_in, b};
		assign dv   = {1'b0, n, 1'b0};
		assign diff = tr - dv;
		assign ge   = (tr >= dv);
		always_ff @(posedge clk) begin
			if (en) begin
				dr_q[t] <= ge ? diff[GB:0] : tr[GB:0];
				dq_q[t] <= {q_in[PHASE_W-2:0], ge};
			end
		end
	end

	assign phase = dq_q[PHASE_W-1];

endmodule
`default_nettype wire

>>> rtl/core/tvg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tvg_front
	import tvg_pkg::*;
#(
	parameter int GB = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tvg_cfg_t           cfg,
	tvg_in_if.sink                  point_in,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output logic [2*GB+2*PHASE_W-1:0] push_data
);

	localparam int L = GB + PHASE_W;

	logic               en;
	logic [L-1:0]       vld_q;
	logic [GB-1:0]      col_q [0:L-1];
	logic [GB-1:0]      row_q [0:L-1];
	logic [PHASE_W-1:0] ph_u;
	logic [PHASE_W-1:0] ph_v;

	// advance unless the last stage holds an item the queue cannot take
	assign en             = !vld_q[L-1] || push_ready;
	assign point_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[L-2:0], point_in.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_q[0] <= point_in.col_index[GB-1:0];
			row_q[0] <= point_in.row_index[GB-1:0];
			for (int i = 1; i < L; i++) begin
				col_q[i] <= col_q[i-1];
				row_q[i] <= row_q[i-1];
			end
		end
	end

	tvg_phase #(.GB(GB)) u_phase_u (
		.clk   (clk),
		.en    (en),
		.k     (point_in.col_index[GB-1:0]),
		.n     (cfg.grid_columns[GB-1:0]),
		.phase (ph_u)
	);

	tvg_phase #(.GB(GB)) u_phase_v (
		.clk   (clk),
		.en    (en),
		.k     (point_in.row_index[GB-1:0]),
		.n     (cfg.grid_rows[GB-1:0]),
		.phase (ph_v)
	);

	assign push_valid = vld_q[L-1];
	assign push_data  = {col_q[L-1], row_q[L-1], ph_u, ph_v};

endmodule
`default_nettype wire

>>> rtl/core/tvg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tvg_queue #(
	parameter int W = 80
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);

	logic [W-1:0] mem_q [0:1];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

>>> rtl/core/tvg_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// rotation CORDIC after a half-turn fold; cos in x, sin in y, both before the flip
module tvg_cordic
	import tvg_pkg::*;
#(
	parameter int T = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [PHASE_W-1:0]     phase,
	output logic signed [XY_W-1:0]      x,
	output logic signed [XY_W-1:0]      y,
	output logic                        flip
);

	logic signed [XY_W-1:0] x_q [0:T-1];
	logic signed [XY_W-1:0] y_q [0:T-1];
	logic signed [Z_W-1:0]  z_q [0:T-1];
	logic                   flip_q [0:T-1];

	logic [PHASE_W-1:0]    ph_rot;
	logic [PHASE_W-1:0]    ph_f;
	logic                  flip0;
	logic signed [Z_W-1:0] z0;

	assign ph_rot = phase + 32'h4000_0000;
	assign flip0  = ph_rot[PHASE_W-1];
	assign ph_f   = flip0 ? phase - 32'h8000_0000 : phase;
	assign z0     = {{(Z_W-PHASE_W){ph_f[PHASE_W-1]}}, ph_f};

	genvar i;
	for (i = 0; i < T; i++) begin : g_stage
		logic signed [XY_W-1:0] xin;
		logic signed [XY_W-1:0] yin;
		logic signed [Z_W-1:0]  zin;
		logic                   fin;
		logic signed [Z_W-1:0]  ang;
		if (i == 0) begin : g_first
			assign xin = CORDIC_GAIN;
			assign yin = '0;
			assign zin = z0;
			assign fin = flip0;
		end else begin : g_next
			assign xin = x_q[i-1];
			assign yin = y_q[i-1];
			assign zin = z_q[i-1];
			assign fin = flip_q[i-1];
		end
		assign ang = {{(Z_W-32){1'b0}}, ATAN_TURNS[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i] <= fin;
				if (!zin[Z_W-1]) begin
					x_q[i] <= xin - (yin >>> i);
					y_q[i] <= yin + (xin >>> i);
					z_q[i] <= zin - ang;
				end else begin
					x_q[i] <= xin + (yin >>> i);
					y_q[i] <= yin - (xin >>> i);
					z_q[i] <= zin + ang;
				end
			end
		end
	end

	assign x    = x_q[T-1];
	assign y    = y_q[T-1];
	assign flip = flip_q[T-1];

endmodule
`default_nettype wire

>>> rtl/core/tvg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tvg_back
	import tvg_pkg::*;
#(
	parameter int GB = 8,
	parameter int T  = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tvg_cfg_t                cfg,
	input  wire logic                    pop_valid,
	output logic                         pop_ready,
	input  wire logic [2*GB+2*PHASE_W-1:0] pop_data,
	tvg_out_if.source                    vertex_out
);

	localparam int IW = 2 * GB + 2;
	localparam logic signed [48:0] SUM_HALF = 49'sd2097152;

	logic               en;
	logic [GB-1:0]      in_col;
	logic [GB-1:0]      in_row;
	logic [PHASE_W-1:0] in_ph_u;
	logic [PHASE_W-1:0] in_ph_v;
	logic [GB-1:0]      nc;
	logic [GB-1:0]      nr;
	logic [GB:0]        w;

	logic signed [XY_W-1:0] xu, yu, xv, yv;
	logic                   fu, fv;

	logic [T-1:0]  vld_c_q;
	logic [GB-1:0] col_c_q [0:T-1];
	logic [GB-1:0] row_c_q [0:T-1];

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [GB-1:0]          col_s1, col_s2, col_s3, row_s1, row_s2;
	logic signed [XY_W-1:0] cu_s1, su_s1, cv_s1, sv_s1;
	logic signed [XY_W-1:0] cu_s2, su_s2, sv_s2, cu_s3, su_s3;
	logic signed [47:0]     rc_s2, pyp_s3, pyp_s4;
	logic signed [63:0]     cucv_s2, sucv_s2;
	logic signed [48:0]     sumr_s3;
	logic signed [17:0]     nx_s3, nz_s3;
	logic signed [16:0]     ny_s3;
	logic [IW-1:0]          base_s3, base_s4;
	logic                   cell_s3, cell_s4;
	logic signed [58:0]     pxp_s4, pzp_s4;
	logic signed [15:0]     nx_s4, ny_s4, nz_s4;

	logic signed [17:0] px_s5, py_s5, pz_s5;
	logic signed [15:0] nx_s5, ny_s5, nz_s5;
	logic               cell_s5;
	logic [15:0]        i00_s5, i10_s5, i01_s5, i11_s5;

	assign {in_col, in_row, in_ph_u, in_ph_v} = pop_data;
	assign nc = cfg.grid_columns[GB-1:0];
	assign nr = cfg.grid_rows[GB-1:0];
	assign w  = {1'b0, nc} + 1'b1;

	// whole back pipe moves whenever the output register is free
	assign en        = !vld_s5 || vertex_out.ready;
	assign pop_ready = en;

	tvg_cordic #(.T(T)) u_cordic_u (
		.clk (clk), .en (en), .phase (in_ph_u), .x (xu), .y (yu), .flip (fu)
	);

	tvg_cordic #(.T(T)) u_cordic_v (
		.clk (clk), .en (en), .phase (in_ph_v), .x (xv), .y (yv), .flip (fv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
		end else if (en) begin
			vld_c_q <= {vld_c_q[T-2:0], pop_valid};
			vld_s1  <= vld_c_q[T-1];
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
		end
	end

	// combinational helpers for the rounding stages
	logic signed [26:0] s16;
	logic signed [63:0] nx_rnd, nz_rnd;
	logic signed [32:0] ny_rnd;
	logic signed [48:0] rbig;
	logic               sum_zero, sum_pos, degen, neg;
	logic signed [18:0] nx_e, ny_e, nz_e;
	logic signed [58:0] px_rnd, pz_rnd;
	logic signed [47:0] py_rnd;
	logic [IW-1:0]      wx;

	assign rbig   = {{3{cfg.ring_radius[15]}}, cfg.ring_radius, 30'd0} | SUM_HALF;
	assign nx_rnd = cucv_s2 + 64'sd35184372088832;
	assign nz_rnd = sucv_s2 + 64'sd35184372088832;
	assign ny_rnd = {sv_s2[XY_W-1], sv_s2} + 33'sd32768;

	assign s16      = sumr_s3[48:22];
	assign sum_zero = (sumr_s3 == SUM_HALF);
	assign sum_pos  = (sumr_s3 > SUM_HALF);
	assign degen    = sum_zero || (cfg.tube_radius == 16'sd0);
	// the normal points inward when S and r have the same sign
	assign neg      = sum_pos == !cfg.tube_radius[15];
	assign nx_e     = neg ? -{nx_s3[17], nx_s3} : {nx_s3[17], nx_s3};
	assign ny_e     = neg ? -{{2{ny_s3[16]}}, ny_s3} : {{2{ny_s3[16]}}, ny_s3};
	assign nz_e     = neg ? -{nz_s3[17], nz_s3} : {nz_s3[17], nz_s3};

	assign px_rnd = pxp_s4 + 59'sd137438953472;
	assign pz_rnd = pzp_s4 + 59'sd137438953472;
	assign py_rnd = pyp_s4 + 48'sd536870912;
	assign wx     = IW'(w);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < T; i++) begin
				if (i == 0) begin
					col_c_q[0] <= in_col;
					row_c_q[0] <= in_row;
				end else begin
					col_c_q[i] <= col_c_q[i-1];
					row_c_q[i] <= row_c_q[i-1];
				end
			end

			// undo the half-turn fold
			cu_s1  <= fu ? -xu : xu;
			su_s1  <= fu ? -yu : yu;
			cv_s1  <= fv ? -xv : xv;
			sv_s1  <= fv ? -yv : yv;
			col_s1 <= col_c_q[T-1];
			row_s1 <= row_c_q[T-1];

			rc_s2   <= cfg.tube_radius * cv_s1;
			cucv_s2 <= cu_s1 * cv_s1;
			sucv_s2 <= su_s1 * cv_s1;
			cu_s2   <= cu_s1;
			su_s2   <= su_s1;
			sv_s2   <= sv_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;

			// S plus the rounding half for the Q.16 view
			sumr_s3 <= rbig + {rc_s2[47], rc_s2};
			nx_s3   <= nx_rnd[63:46];
			nz_s3   <= nz_rnd[63:46];
			ny_s3   <= ny_rnd[32:16];
			pyp_s3  <= cfg.tube_radius * sv_s2;
			base_s3 <= IW'(row_s2) * wx;
			cell_s3 <= (col_s2 < nc) && (row_s2 < nr);
			cu_s3   <= cu_s2;
			su_s3   <= su_s2;
			col_s3  <= col_s2;

			pxp_s4  <= s16 * cu_s3;
			pzp_s4  <= s16 * su_s3;
			pyp_s4  <= pyp_s3;
			nx_s4   <= degen ? 16'sd0 : clamp_norm(nx_e);
			ny_s4   <= degen ? 16'sd0 : clamp_norm(ny_e);
			nz_s4   <= degen ? 16'sd0 : clamp_norm(nz_e);
			base_s4 <= base_s3 + IW'(col_s3);
			cell_s4 <= cell_s3;

			px_s5   <= clamp_pos(px_rnd[58:38]);
			pz_s5   <= clamp_pos(pz_rnd[58:38]);
			py_s5   <= py_rnd[47:30];
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			nz_s5   <= nz_s4;
			cell_s5 <= cell_s4;
			if (cell_s4) begin
				i00_s5 <= base_s4[15:0];
				i10_s5 <= 16'(base_s4 + 1'b1);
				i01_s5 <= 16'(base_s4 + wx);
				i11_s5 <= 16'(base_s4 + wx + 1'b1);
			end else begin
				i00_s5 <= '0;
				i10_s5 <= '0;
				i01_s5 <= '0;
				i11_s5 <= '0;
			end
		end
	end

	assign vertex_out.valid        = vld_s5;
	assign vertex_out.pos_x        = px_s5;
	assign vertex_out.pos_y        = py_s5;
	assign vertex_out.pos_z        = pz_s5;
	assign vertex_out.norm_x       = nx_s5;
	assign vertex_out.norm_y       = ny_s5;
	assign vertex_out.norm_z       = nz_s5;
	assign vertex_out.cell_valid   = cell_s5;
	assign vertex_out.idx_corner00 = i00_s5;
	assign vertex_out.idx_corner10 = i10_s5;
	assign vertex_out.idx_corner01 = i01_s5;
	assign vertex_out.idx_corner11 = i11_s5;

endmodule
`default_nettype wire

>>> rtl/core/torus_vertex_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one point per cycle; the front divider pipe and both CORDIC pipes take a new
//   item every cycle. A stalled output holds the back pipe; the front keeps going until the
//   two-entry queue fills, then holds too.
// Reset (arst_n low, asynchronous): all pipes and the queue empty, registers go to
//   16 columns, 16 rows, R = 1.0 and r = 0.25.
module torus_vertex_generator_core
	import tvg_pkg::*;
#(
	parameter int GRID_BITS   = 8,
	parameter int TRIG_STAGES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tvg_in_if.sink                     point_in,
	tvg_out_if.source                  vertex_out
);

	localparam int QW = 2 * GRID_BITS + 2 * PHASE_W;
	localparam logic [7:0] GRID_MASK = 8'((1 << GRID_BITS) - 1);

	logic [7:0]         grid_columns_q;
	logic [7:0]         grid_rows_q;
	logic signed [15:0] ring_radius_q;
	logic signed [15:0] tube_radius_q;
	logic [7:0]         cols_m;
	logic [7:0]         rows_m;
	tvg_cfg_t           cfg;

	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0] push_data, pop_data;

	// register file; to be written only while the block is idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 8'd16;
			grid_rows_q    <= 8'd16;
			ring_radius_q  <= 16'sd256;
			tube_radius_q  <= 16'sd64;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[7:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[7:0];
				REG_MAJOR_RADIUS: ring_radius_q  <= cfg_data;
				REG_MINOR_RADIUS: tube_radius_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// mask sizes to the grid width; a zero size behaves as one segment
	assign cols_m = grid_columns_q & GRID_MASK;
	assign rows_m = grid_rows_q & GRID_MASK;
	assign cfg.grid_columns = (cols_m == 8'd0) ? 8'd1 : cols_m;
	assign cfg.grid_rows    = (rows_m == 8'd0) ? 8'd1 : rows_m;
	assign cfg.ring_radius  = ring_radius_q;
	assign cfg.tube_radius  = tube_radius_q;

	// front: angle phases from the grid point via pipelined modulo and divide
	tvg_front #(.GB(GRID_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.point_in   (point_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// two-entry queue decouples the divider pipe from the trig/math pipe
	tvg_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: CORDIC for both angles, then position, normal and quad indices
	tvg_back #(.GB(GRID_BITS), .T(TRIG_STAGES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.vertex_out (vertex_out)
	);

endmodule
`default_nettype wire

>>> rtl/core/tvg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tvg_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [17:0] pos_x,
	input wire logic signed [15:0] norm_x,
	input wire logic signed [15:0] norm_y,
	input wire logic signed [15:0] norm_z,
	input wire logic               cell_valid,
	input wire logic [15:0]        idx_corner00,
	input wire logic [15:0]        idx_corner10,
	input wire logic [15:0]        idx_corner01,
	input wire logic [15:0]        idx_corner11
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("vertex dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(idx_corner00))
		else $error("vertex changed while stalled");

	a_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_valid |-> idx_corner00 == 16'd0 && idx_corner10 == 16'd0
			&& idx_corner01 == 16'd0 && idx_corner11 == 16'd0)
		else $error("quad indices set outside the grid");

	a_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_valid |-> idx_corner10 == 16'(idx_corner00 + 16'd1)
			&& idx_corner11 == 16'(idx_corner01 + 16'd1))
		else $error("quad corners not adjacent");

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_x >= -16'sd16384 && norm_x <= 16'sd16384
			&& norm_y >= -16'sd16384 && norm_y <= 16'sd16384
			&& norm_z >= -16'sd16384 && norm_z <= 16'sd16384)
		else $error("normal component out of range");

endmodule

bind torus_vertex_generator_core tvg_checker u_tvg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (vertex_out.valid),
	.out_ready    (vertex_out.ready),
	.pos_x        (vertex_out.pos_x),
	.norm_x       (vertex_out.norm_x),
	.norm_y       (vertex_out.norm_y),
	.norm_z       (vertex_out.norm_z),
	.cell_valid   (vertex_out.cell_valid),
	.idx_corner00 (vertex_out.idx_corner00),
	.idx_corner10 (vertex_out.idx_corner10),
	.idx_corner01 (vertex_out.idx_corner01),
	.idx_corner11 (vertex_out.idx_corner11)
);
`default_nettype wire
